### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define SST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sst assertion failed");

// Next-cycle implication, reset masked.
`define SST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sst assertion failed");

`endif

### src/sst_pkg.sv
// Types and constants of the sprite sort batcher.
`default_nettype none
package sst_pkg;
    localparam int DEPTH_W  = 16;
    localparam int TEX_W    = 16;
    localparam int IDX_W    = 6;
    localparam int BOFF_W   = 9;
    localparam int VERTS_PER_SPRITE = 6;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [APB_AW-1:0] ADDR_SORT_MODE = 3'd0;

    localparam logic [1:0] MODE_BACK_TO_FRONT = 2'd0;
    localparam logic [1:0] MODE_FRONT_TO_BACK = 2'd1;
    localparam logic [1:0] MODE_BY_TEXTURE    = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef logic [1:0] t_mode;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [TEX_W-1:0]          tex;
        logic [IDX_W-1:0]          idx;
    } t_rec;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } t_cell_ctl;
endpackage
`default_nettype wire

### src/sst_ifs.sv
// Handshake interfaces for the request and result words.
`default_nettype none
interface sst_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [sst_pkg::DEPTH_W-1:0]  depth;
    logic [sst_pkg::TEX_W-1:0]           texture;
    modport source (output valid, req_type, depth, texture, input ready);
    modport sink (input valid, req_type, depth, texture, output ready);
endinterface

interface sst_res_if;
    logic                         valid;
    logic                         ready;
    logic [sst_pkg::IDX_W-1:0]    sprite_index;
    logic [sst_pkg::TEX_W-1:0]    tex_id;
    logic                         batch_start;
    logic [sst_pkg::BOFF_W-1:0]   batch_offset;
    logic                         overflowed;
    logic                         last;
    modport source (output valid, sprite_index, tex_id, batch_start, batch_offset,
                    overflowed, last, input ready);
    modport sink (input valid, sprite_index, tex_id, batch_start, batch_offset,
                  overflowed, last, output ready);
endinterface
`default_nettype wire

### src/stable_sort_texture_batcher.sv
// Sprite sort batcher top level: cell row, sequencer, result register, APB register.
//
// Load words write one sprite record into the next free cell of a row of
// MAX_SPRITES cells, one load per cycle; loads past capacity are dropped and
// flagged. An end word starts an odd-even transposition sort along the row:
// each cycle every other neighbour pair swaps when the right record strictly
// precedes the left one under sort_mode, so equal keys keep arrival order.
// The sort runs one round of the row per stored sprite. The row then shifts
// towards cell 0, one result word per cycle into the output register as the
// sink accepts, carrying batch start and the batch's vertex offset (6
// vertices per sprite). While sorting and emitting, no request word is
// accepted; an end word on an empty store starts no sort. Loads resume as
// soon as the last result has entered the output register. sort_mode sits
// at APB byte address 0.
`default_nettype none
module stable_sort_texture_batcher #(
    parameter int MAX_SPRITES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sst_req_if.sink                            i_req,
    sst_res_if.source                          o_res,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [sst_pkg::APB_AW-1:0]    i_paddr,
    input  wire logic [sst_pkg::APB_DW-1:0]    i_pwdata,
    output logic [sst_pkg::APB_DW-1:0]         o_prdata,
    output logic                               o_pready
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(MAX_SPRITES + 1);

    typedef enum logic [1:0] {S_LOAD, S_SORT, S_EMIT} t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;   // records held this frame
    logic [CNT_W-1:0]   r_pass;    // sort round
    logic               r_phase;   // even or odd pairs this round
    logic [CNT_W-1:0]   r_pos;     // sorted position of next result
    logic               r_drop;
    logic               r_ovf;     // drop flag latched for the frame being emitted
    t_mode              r_mode;
    logic [TEX_W-1:0]   r_prev_tex;
    logic [BOFF_W-1:0]  r_boff;

    // result register
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [TEX_W-1:0]   r_out_tex;
    logic               r_out_start;
    logic [BOFF_W-1:0]  r_out_boff;
    logic               r_out_ovf;
    logic               r_out_last;

    t_rec               rec [MAX_SPRITES];
    logic               before_left [MAX_SPRITES];
    t_cell_ctl          ctl [MAX_SPRITES];
    t_rec               new_rec;

    logic               in_acc;
    logic               out_free;
    logic               emit_shift;
    logic               emit_start;
    logic               emit_last;
    logic [BOFF_W-1:0]  emit_boff;

    // ---- APB register ----
    assign o_pready = 1'b1;
    always_comb begin
        if (i_paddr == ADDR_SORT_MODE) begin
            o_prdata = {{(APB_DW-2){1'b0}}, r_mode};
        end else begin
            o_prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BACK_TO_FRONT;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr == ADDR_SORT_MODE) begin
            r_mode <= i_pwdata[1:0];
        end
    end

    // ---- handshakes ----
    assign i_req.ready = (r_state == S_LOAD);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign emit_shift  = (r_state == S_EMIT) && out_free;

    assign new_rec.depth = i_req.depth;
    assign new_rec.tex   = i_req.texture;
    assign new_rec.idx   = IDX_W'(r_count);

    // batch bookkeeping for the record at the head of the row
    assign emit_start = (r_pos == '0) || (rec[0].tex != r_prev_tex);
    assign emit_last  = (r_pos == r_count - CNT_W'(1));
    assign emit_boff  = emit_start ? BOFF_W'(r_pos) * BOFF_W'(VERTS_PER_SPRITE) : r_boff;

    // ---- cell row ----
    for (genvar g = 0; g < MAX_SPRITES; g++) begin : g_cell
        t_rec left_rec;
        t_rec right_rec;
        logic pair_l;
        logic pair_r;

        if (g == 0) begin : g_head
            assign left_rec = rec[0];
            assign pair_l   = 1'b0;
        end else begin : g_mid
            assign left_rec = rec[g-1];
            assign pair_l   = (r_state == S_SORT) && (r_phase == 1'((g - 1) % 2))
                              && (CNT_W'(g) < r_count) && before_left[g];
        end

        if (g == MAX_SPRITES - 1) begin : g_tail
            assign right_rec = rec[g];
            assign pair_r    = 1'b0;
        end else begin : g_body
            assign right_rec = rec[g+1];
            assign pair_r    = ((r_state == S_SORT) && (r_phase == 1'(g % 2))
                                && (CNT_W'(g + 1) < r_count) && before_left[g+1])
                               || emit_shift;
        end

        assign ctl[g].load       = in_acc && (i_req.req_type == REQ_LOAD)
                                   && (r_count == CNT_W'(g));
        assign ctl[g].take_left  = pair_l;
        assign ctl[g].take_right = pair_r;

        sst_cell u_cell (
            .i_clk         (i_clk),
            .i_mode        (r_mode),
            .i_ctl         (ctl[g]),
            .i_new         (new_rec),
            .i_left        (left_rec),
            .i_right       (right_rec),
            .o_rec         (rec[g]),
            .o_before_left (before_left[g])
        );
    end

    // ---- sequencer and result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_pass      <= '0;
            r_phase     <= 1'b0;
            r_pos       <= '0;
            r_drop      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new word enters whenever the register frees up during emit
            if (emit_shift) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_req.req_type == REQ_LOAD) begin
                            if (r_count < CNT_W'(MAX_SPRITES)) begin
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                r_drop <= 1'b1;
                            end
                        end else begin
                            r_drop <= 1'b0;
                            if (r_count != '0) begin
                                r_ovf   <= r_drop;
                                r_pass  <= '0;
                                r_phase <= 1'b0;
                                r_state <= S_SORT;
                            end
                        end
                    end
                end
                S_SORT: begin
                    r_pass  <= r_pass + CNT_W'(1);
                    r_phase <= ~r_phase;
                    if (r_pass == r_count - CNT_W'(1)) begin
                        r_pos   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_pos <= r_pos + CNT_W'(1);
                        if (emit_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // payload side, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit_shift) begin
            r_prev_tex  <= rec[0].tex;
            r_boff      <= emit_boff;
            r_out_idx   <= rec[0].idx;
            r_out_tex   <= rec[0].tex;
            r_out_start <= emit_start;
            r_out_boff  <= emit_boff;
            r_out_ovf   <= r_ovf;
            r_out_last  <= emit_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.sprite_index = r_out_idx;
    assign o_res.tex_id       = r_out_tex;
    assign o_res.batch_start  = r_out_start;
    assign o_res.batch_offset = r_out_boff;
    assign o_res.overflowed   = r_out_ovf;
    assign o_res.last         = r_out_last;
endmodule
`default_nettype wire

### src/sst_cell.sv
// One cell of the sort row: holds a record, compares with its left neighbour.
`default_nettype none
module sst_cell (
    input  wire logic               i_clk,
    input  wire sst_pkg::t_mode     i_mode,
    input  wire sst_pkg::t_cell_ctl i_ctl,
    input  wire sst_pkg::t_rec      i_new,
    input  wire sst_pkg::t_rec      i_left,
    input  wire sst_pkg::t_rec      i_right,
    output sst_pkg::t_rec           o_rec,
    output logic                    o_before_left
);
    import sst_pkg::*;

    t_rec r_rec;
    t_rec n_rec;

    // strict ordering only, so equal keys never swap (stable)
    always_comb begin
        case (i_mode)
            MODE_BACK_TO_FRONT: o_before_left = $signed(r_rec.depth) > $signed(i_left.depth);
            MODE_FRONT_TO_BACK: o_before_left = $signed(r_rec.depth) < $signed(i_left.depth);
            MODE_BY_TEXTURE:    o_before_left = r_rec.tex < i_left.tex;
            default:            o_before_left = 1'b0;
        endcase
    end

    always_comb begin
        if (i_ctl.load) begin
            n_rec = i_new;
        end else if (i_ctl.take_left) begin
            n_rec = i_left;
        end else if (i_ctl.take_right) begin
            n_rec = i_right;
        end else begin
            n_rec = r_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;
endmodule
`default_nettype wire

### src/sst_checker.sv
// Port-level assertions for the sprite sort batcher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sst_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [sst_pkg::IDX_W-1:0]   i_out_idx,
    input wire logic [sst_pkg::TEX_W-1:0]   i_out_tex,
    input wire logic                        i_out_start,
    input wire logic [sst_pkg::BOFF_W-1:0]  i_out_boff,
    input wire logic                        i_out_last,
    input wire logic                        i_psel,
    input wire logic                        i_penable,
    input wire logic                        i_pwrite,
    input wire logic [sst_pkg::APB_AW-1:0]  i_paddr,
    input wire logic [sst_pkg::APB_DW-1:0]  i_pwdata,
    input wire logic [sst_pkg::APB_DW-1:0]  i_prdata
);
    import sst_pkg::*;

    // a stalled result word holds
    `SST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_idx) && $stable(i_out_tex) && $stable(i_out_boff) && $stable(i_out_start) && $stable(i_out_last))

    // mid-frame results block new requests
    `SST_ASSERT_IMP(a_emit_blocks, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

    // within a batch the vertex offset carries over
    `SST_ASSERT_IMP(a_boff_carry, i_clk, i_rst_n, (i_out_valid && i_out_ready && !i_out_last) ##1 (i_out_valid && i_out_ready && !i_out_start), i_out_boff == $past(i_out_boff))

    // sort_mode reads back what was written
    `SST_ASSERT_NXT(a_mode_rb, i_clk, i_rst_n, i_psel && i_penable && i_pwrite && i_paddr == ADDR_SORT_MODE, i_paddr != ADDR_SORT_MODE || i_prdata[1:0] == $past(i_pwdata[1:0]))
endmodule

bind stable_sort_texture_batcher sst_checker u_sst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_idx   (o_res.sprite_index),
    .i_out_tex   (o_res.tex_id),
    .i_out_start (o_res.batch_start),
    .i_out_boff  (o_res.batch_offset),
    .i_out_last  (o_res.last),
    .i_psel      (i_psel),
    .i_penable   (i_penable),
    .i_pwrite    (i_pwrite),
    .i_paddr     (i_paddr),
    .i_pwdata    (i_pwdata),
    .i_prdata    (o_prdata)
);
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the sprite sort batcher: directed and random frames in all modes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    // Store capacity used for the instance and for the predictor.
    localparam int CAP = 64;
    // Encoding 3 of sort_mode is unused by the block and keeps arrival order.
    localparam t_mode MODE_KEEP_ORDER = 2'd3;
    // Settling wait, sized from CAP to cover a full frame's sort and drain.
    localparam int DRAIN_CYCLES = 2 * CAP + 24;
    localparam int LONG_HOLD = 400;
    localparam int WORDS_TARGET = 430;
    // Well above a run where every word fills a frame and every result stalls.
    localparam longint CYCLE_LIMIT = 2000000;

    // One expected result word.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [TEX_W-1:0]  tex;
        logic              start;
        logic [BOFF_W-1:0] boff;
        logic              ovf;
        logic              last;
    } t_sprite_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_psel;
    logic              i_penable;
    logic              i_pwrite;
    logic [APB_AW-1:0] i_paddr;
    logic [APB_DW-1:0] i_pwdata;
    logic [APB_DW-1:0] o_prdata;
    logic              o_pready;

    sst_req_if req_if();
    sst_res_if res_if();

    stable_sort_texture_batcher #(
        .MAX_SPRITES(CAP)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_res     (res_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Predictor's own copy of the sprite store and the register.
    logic signed [DEPTH_W-1:0] shadow_depth [CAP];
    logic [TEX_W-1:0]          shadow_tex [CAP];
    int                        shadow_fill = 0;
    bit                        shadow_drop = 1'b0;
    t_mode                     shadow_mode = MODE_BACK_TO_FRONT;

    // Sorted sprites still owed by the block, oldest first.
    t_sprite_res pending_sprites [$];

    bit     idle_on = 1'b1;       // random gaps on both sides
    bit     hold_request = 1'b0;  // asks the result side for one long hold-off
    int     n_errors = 0;
    int     words_sent = 0;
    int     frames_sent = 0;
    int     results_seen = 0;
    int     overflow_frames = 0;
    longint cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Strict ordering under the current mode; ties never swap, so the sort is stable.
    function automatic bit precedes(input int a, input int b);
        case (shadow_mode)
            MODE_BACK_TO_FRONT: return shadow_depth[a] > shadow_depth[b];
            MODE_FRONT_TO_BACK: return shadow_depth[a] < shadow_depth[b];
            MODE_BY_TEXTURE:    return shadow_tex[a] < shadow_tex[b];
            default:            return 1'b0;
        endcase
    endfunction

    // Applies one accepted request word; an end word queues the sorted frame.
    function automatic void sort_and_batch(input logic rt, input logic signed [DEPTH_W-1:0] d,
                                           input logic [TEX_W-1:0] t);
        int                ord [CAP];
        int                n;
        int                j;
        logic [BOFF_W-1:0] boff;
        t_sprite_res       r;
        if (rt == REQ_LOAD) begin
            if (shadow_fill < CAP) begin
                shadow_depth[shadow_fill] = d;
                shadow_tex[shadow_fill] = t;
                shadow_fill++;
            end else begin
                shadow_drop = 1'b1;
            end
            return;
        end
        n = shadow_fill;
        // stable insertion sort over store positions (position = arrival index)
        for (int i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && precedes(i, ord[j-1])) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = i;
        end
        boff = '0;
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                r.start = 1'b1;
            else
                r.start = shadow_tex[ord[i]] != shadow_tex[ord[i-1]];
            if (r.start)
                boff = BOFF_W'(i * VERTS_PER_SPRITE);
            r.idx  = IDX_W'(ord[i]);
            r.tex  = shadow_tex[ord[i]];
            r.boff = boff;
            r.ovf  = shadow_drop;
            r.last = (i == n - 1);
            pending_sprites.insert(pending_sprites.size(), r);
        end
        if (shadow_drop)
            overflow_frames++;
        shadow_fill = 0;
        shadow_drop = 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Result side: ready pattern and checking
    // ---------------------------------------------------------------

    // Random ready bursts, plus one long counted hold-off on request.
    initial begin : result_sink
        int held;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(posedge i_clk);
                    held++;
                end
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Each accepted result word is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_sprite_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_sprites.size() == 0) begin
                n_errors++;
                $display("%0t: result word with nothing expected, expected none, got idx %0d tex %h",
                         $time, res_if.sprite_index, res_if.tex_id);
            end else begin
                want = pending_sprites.pop_front();
                check_field("sprite_index", 32'(want.idx), 32'(res_if.sprite_index));
                check_field("tex_id", 32'(want.tex), 32'(res_if.tex_id));
                check_field("batch_start", 32'(want.start), 32'(res_if.batch_start));
                check_field("batch_offset", 32'(want.boff), 32'(res_if.batch_offset));
                check_field("overflowed", 32'(want.ovf), 32'(res_if.overflowed));
                check_field("last", 32'(want.last), 32'(res_if.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // Offers one request word and waits for it to be taken. valid stays high
    // between back-to-back words; it only drops for a gap or at the end of a phase.
    task automatic send_word(input logic rt, input logic signed [DEPTH_W-1:0] d,
                             input logic [TEX_W-1:0] t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rt;
        req_if.depth    <= d;
        req_if.texture  <= t;
        do @(posedge i_clk); while (!req_if.ready);
        sort_and_batch(rt, d, t);
        words_sent++;
    endtask

    // Depths: extremes, a narrow band that forces ties, or anything.
    function automatic logic signed [DEPTH_W-1:0] random_depth();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       return $signed(16'($urandom_range(0, 6)) - 16'd3);
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Textures: mostly a small pool so that batches form, sometimes anything.
    function automatic logic [TEX_W-1:0] random_tex();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2:    return 16'h0010 + 16'($urandom_range(0, 3));
            default: return 16'($urandom());
        endcase
    endfunction

    // Mostly small frames; now and then empty, full, or past capacity.
    function automatic int random_frame_size();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return CAP;
            2:       return CAP + $urandom_range(1, 5);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    task automatic send_frame(input int n_loads);
        for (int k = 0; k < n_loads; k++)
            send_word(REQ_LOAD, random_depth(), random_tex());
        // depth and texture of an end word are don't-care; randomise them anyway
        send_word(REQ_END, random_depth(), random_tex());
        frames_sent++;
    endtask

    // Block is idle once every result is in and the sort/drain window has passed.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (pending_sprites.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_sort_mode(input t_mode m);
        settle();
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= ADDR_SORT_MODE;
        i_pwdata  <= APB_DW'(m);
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        shadow_mode = m;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset mode (back to front): depth and texture extremes, equal depths,
    // repeated textures so that batches open and close.
    task automatic test_directed_frame();
        logic signed [DEPTH_W-1:0] dd [10] = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1,
                                              16'sd1, 16'sh0000, 16'sh0100, 16'sh8000,
                                              -16'sd256, 16'sh0000};
        logic [TEX_W-1:0]          tt [10] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                                              16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555,
                                              16'h0000, 16'h5555};
        for (int k = 0; k < 10; k++)
            send_word(REQ_LOAD, dd[k], tt[k]);
        send_word(REQ_END, 16'sh0000, 16'h0000);
        frames_sent++;
    endtask

    // End word on an empty store gives no results and must leave state intact.
    task automatic test_empty_frame();
        send_frame(0);
        send_frame(2);
    endtask

    // Unused mode encoding: output follows arrival order.
    task automatic test_keep_order_mode();
        write_sort_mode(MODE_KEEP_ORDER);
        send_frame(6);
    endtask

    // Long result hold-off during a large frame; the next frame's loads keep
    // being offered and must stall until the drain is done.
    task automatic test_backpressure();
        write_sort_mode(MODE_BY_TEXTURE);
        for (int k = 0; k < 48; k++)
            send_word(REQ_LOAD, random_depth(), random_tex());
        send_word(REQ_END, random_depth(), random_tex());
        frames_sent++;
        // the sort of 48 records outlasts any ready burst, so the hold lands on the drain
        hold_request = 1'b1;
        send_frame(8);
    endtask

    // Random frames, several per sort mode, modes stepped through every encoding.
    task automatic test_random_frames();
        t_mode modes [6] = '{MODE_FRONT_TO_BACK, MODE_BY_TEXTURE, MODE_KEEP_ORDER,
                            MODE_BACK_TO_FRONT, MODE_BY_TEXTURE, MODE_FRONT_TO_BACK};
        int    phase;
        phase = 0;
        while (words_sent < WORDS_TARGET - 50) begin
            write_sort_mode(modes[phase % 6]);
            phase++;
            repeat ($urandom_range(2, 4)) send_frame(random_frame_size());
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_sort_mode(MODE_BACK_TO_FRONT);
        while (words_sent < WORDS_TARGET)
            send_frame($urandom_range(1, 12));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_LOAD;
        req_if.depth    = '0;
        req_if.texture  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frame();
        test_empty_frame();
        test_keep_order_mode();
        test_backpressure();
        test_random_frames();
        test_steady_stream();
        settle();

        $display("Covered %0d request words in %0d frames (%0d past capacity), all sort modes,",
                 words_sent, frames_sent, overflow_frames);
        $display("with %0d sprite result words checked under random and long stalls.",
                 results_seen);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
